@@ design/bsbr_pkg.sv @@
// Shared types, register offsets and bank offset tables for the bank switch board registers.
// No dependencies; the bank decoder and the top level import this package.
`default_nettype none

package bsbr_pkg;

    // Bus access kinds
    typedef enum logic [1:0] {
        MODE_REG_READ   = 2'd0,
        MODE_REG_WRITE  = 2'd1,
        MODE_BANK_READ  = 2'd2,
        MODE_BANK_WRITE = 2'd3
    } mode_t;

    // Register offsets from the base
    localparam logic [13:0] OFS_PORT_B        = 14'h00;
    localparam logic [13:0] OFS_PORT_A        = 14'h01;
    localparam logic [13:0] OFS_DDR_B         = 14'h02;
    localparam logic [13:0] OFS_DDR_A         = 14'h03;
    localparam logic [13:0] OFS_PLAIN_FIRST   = 14'h04;
    localparam logic [13:0] OFS_PLAIN_LAST    = 14'h0e;
    localparam logic [13:0] OFS_PORT_A_MIRROR = 14'h0f;
    localparam logic [13:0] OFS_CONTROL       = 14'h22;
    localparam logic [13:0] OFS_BANK_SET      = 14'h23;

    // Plain VIA bytes that can be addressed (offsets 0x04..0x0e)
    localparam int unsigned PLAIN_COUNT = 11;

    // Reset values
    localparam logic [7:0] PORT_A_RESET   = 8'h07;
    localparam logic [7:0] DDR_A_RESET    = 8'ha7;
    localparam logic [7:0] DDR_B_RESET    = 8'hc0;
    localparam logic [7:0] CONTROL_BASE   = 8'h80;
    localparam logic [1:0] VERSION_RESET  = 2'd2;
    localparam int unsigned CTRL_RAM_BIT  = 5;

    // Highest bank number the decoder can produce
    localparam logic [5:0] BANK_MAX = 6'd32;

    // Bank offset tables, indexed by the low bits of the bank-set register
    localparam logic [5:0] ROM_TAB [8] = '{6'd0, 6'd8, 6'd12, 6'd16, 6'd4, 6'd20, 6'd24, 6'd28};
    localparam logic [5:0] RAM_TAB [8] = '{6'd0, 6'd4, 6'd8, 6'd12, 6'd16, 6'd20, 6'd24, 6'd28};

    // Decoded bank selection
    typedef struct packed {
        logic       is_ram;
        logic [5:0] bank;
    } bank_sel_t;

    // One result item
    typedef struct packed {
        logic [7:0]  read_data;
        logic        accepted;
        logic        mem_request;
        logic        mem_write;
        logic        mem_is_ram;
        logic [5:0]  mem_bank;
        logic [13:0] mem_offset;
        logic [7:0]  mem_write_data;
    } result_t;

    // Port write: input bits read back high
    function automatic logic [7:0] drive(input logic [7:0] data, input logic [7:0] dir);
        drive = (data & dir) | ~dir;
    endfunction

endpackage

`default_nettype wire

@@ design/bsbr_if.sv @@
// Valid/ready channel interfaces for bus accesses, results and the version write port.
// Depends on nothing; used by the top level bank_switch_board_registers.
`default_nettype none

interface bsbr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [13:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output mode, output address, output write_data, input ready);
    modport sink   (input valid, input mode, input address, input write_data, output ready);
endinterface

interface bsbr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        accepted;
    logic        mem_request;
    logic        mem_write;
    logic        mem_is_ram;
    logic [5:0]  mem_bank;
    logic [13:0] mem_offset;
    logic [7:0]  mem_write_data;

    modport source (
        output valid, output read_data, output accepted, output mem_request,
        output mem_write, output mem_is_ram, output mem_bank, output mem_offset,
        output mem_write_data, input ready
    );
    modport sink (
        input valid, input read_data, input accepted, input mem_request,
        input mem_write, input mem_is_ram, input mem_bank, input mem_offset,
        input mem_write_data, output ready
    );
endinterface

interface bsbr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/bsbr_bank_decode.sv @@
// Bank decoder: maps port A select bits, the control RAM bit and the bank set to a bank.
// Depends on bsbr_pkg for the offset tables and bank_sel_t.
`default_nettype none

module bsbr_bank_decode
    import bsbr_pkg::*;
(
    input  wire logic [2:0] port_a_sel,
    input  wire logic       ram_enable,
    input  wire logic [2:0] set_sel,
    output bank_sel_t       sel
);

    logic [5:0] base;

    assign base = {3'b000, port_a_sel};

    // Pick the store and add the table offset for the overlay banks
    always_comb
    begin
        priority if (port_a_sel == 3'd0)
        begin
            sel.is_ram = 1'b1;
            sel.bank   = 6'd0;
        end
        else if (port_a_sel >= 3'd5)
        begin
            sel.is_ram = 1'b0;
            sel.bank   = base;
        end
        else if (ram_enable)
        begin
            sel.is_ram = 1'b1;
            sel.bank   = base + RAM_TAB[set_sel];
        end
        else
        begin
            sel.is_ram = 1'b0;
            sel.bank   = base + ROM_TAB[set_sel];
        end
    end

endmodule

`default_nettype wire

@@ design/bank_switch_board_registers.sv @@
// An input transfer's result goes into the output register, or the skid entry if that is held.
// Throughput: one bus access per cycle while the skid entry is free; register update,
// read mux and bank decode are one level of logic ahead of the result register.
// A two-entry output buffer (result register plus skid entry) keeps input ready
// while one result waits; input ready drops only when both entries are full.
// Reset (rst_n low, asynchronous) loads the VIA and control defaults, empties the buffer.
`default_nettype none

module bank_switch_board_registers
    import bsbr_pkg::*;
#(
    parameter int unsigned BANK_BYTES = 16384
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bsbr_in_if.sink     bus_in,
    bsbr_out_if.source  bus_out,
    bsbr_cfg_if.sink    cfg
);

    localparam int unsigned OFFSET_BITS = $clog2(BANK_BYTES);

    // Register file
    logic [7:0] port_b_reg,    port_b_next;
    logic [7:0] port_a_reg,    port_a_next;
    logic [7:0] port_a_mir_reg, port_a_mir_next;
    logic [7:0] ddr_b_reg,     ddr_b_next;
    logic [7:0] ddr_a_reg,     ddr_a_next;
    logic [7:0] plain_reg [PLAIN_COUNT];
    logic [7:0] control_reg,   control_next;
    logic [7:0] bank_set_reg,  bank_set_next;
    logic [1:0] version_reg,   version_next;

    // Output buffer
    logic       out_valid_reg,  out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    result_t    out_data_reg;
    result_t    skid_data_reg;

    logic       in_xfer;
    logic       out_xfer;
    logic       is_write;
    logic       plain_hit;
    logic [3:0] plain_idx;
    logic [13:0] offset;
    bank_sel_t  bank_sel;
    result_t    res;

    assign in_xfer   = bus_in.valid && bus_in.ready;
    assign out_xfer  = out_valid_reg && bus_out.ready;
    assign is_write  = (bus_in.mode == MODE_REG_WRITE);
    assign plain_hit = (bus_in.address >= OFS_PLAIN_FIRST) && (bus_in.address <= OFS_PLAIN_LAST);
    assign plain_idx = bus_in.address[3:0] - OFS_PLAIN_FIRST[3:0];
    assign cfg.ready = 1'b1;

    // Byte offset inside the bank
    generate
        if (OFFSET_BITS >= 14)
        begin : g_offset_full
            assign offset = bus_in.address;
        end
        else
        begin : g_offset_mask
            assign offset = {{(14 - OFFSET_BITS){1'b0}}, bus_in.address[OFFSET_BITS-1:0]};
        end
    endgenerate

    bsbr_bank_decode u_bank_decode (
        .port_a_sel (port_a_reg[2:0]),
        .ram_enable (control_reg[CTRL_RAM_BIT]),
        .set_sel    (bank_set_reg[2:0]),
        .sel        (bank_sel)
    );

    // Decode the access: register updates and the result item
    always_comb
    begin
        port_b_next     = port_b_reg;
        port_a_next     = port_a_reg;
        port_a_mir_next = port_a_mir_reg;
        ddr_b_next      = ddr_b_reg;
        ddr_a_next      = ddr_a_reg;
        control_next    = control_reg;
        bank_set_next   = bank_set_reg;
        version_next    = version_reg;
        res             = '0;
        res.accepted    = 1'b1;

        if (!bus_in.mode[1])
        begin
            priority if (bus_in.address == OFS_PORT_B)
            begin
                res.read_data = port_b_reg;
                port_b_next   = drive(bus_in.write_data, ddr_b_reg);
            end
            else if (bus_in.address == OFS_PORT_A || bus_in.address == OFS_PORT_A_MIRROR)
            begin
                res.read_data   = (bus_in.address == OFS_PORT_A) ? port_a_reg : port_a_mir_reg;
                port_a_next     = drive(bus_in.write_data, ddr_a_reg);
                port_a_mir_next = port_a_next;
            end
            else if (bus_in.address == OFS_DDR_B)
            begin
                res.read_data = ddr_b_reg;
                ddr_b_next    = bus_in.write_data;
            end
            else if (bus_in.address == OFS_DDR_A)
            begin
                res.read_data = ddr_a_reg;
                ddr_a_next    = bus_in.write_data;
            end
            else if (plain_hit)
            begin
                res.read_data = plain_reg[plain_idx];
            end
            else if (bus_in.address == OFS_CONTROL)
            begin
                res.read_data = control_reg;
                control_next  = bus_in.write_data;
            end
            else if (bus_in.address == OFS_BANK_SET)
            begin
                res.read_data = bank_set_reg;
                bank_set_next = bus_in.write_data;
            end
            else
            begin
                res.accepted = 1'b0;
            end

            // Register writes read back zero and only a write changes state
            if (is_write)
            begin
                res.read_data = '0;
            end
            else
            begin
                port_b_next     = port_b_reg;
                port_a_next     = port_a_reg;
                port_a_mir_next = port_a_mir_reg;
                ddr_b_next      = ddr_b_reg;
                ddr_a_next      = ddr_a_reg;
                control_next    = control_reg;
                bank_set_next   = bank_set_reg;
            end
        end
        else if (!bus_in.mode[0] || bank_sel.is_ram)
        begin
            // Bank access; writes to ROM are dropped
            res.mem_request    = 1'b1;
            res.mem_write      = bus_in.mode[0];
            res.mem_is_ram     = bank_sel.is_ram;
            res.mem_bank       = bank_sel.bank;
            res.mem_offset     = offset;
            res.mem_write_data = bus_in.mode[0] ? bus_in.write_data : 8'h00;
        end

        // Hold state unless a transfer happens
        if (!in_xfer)
        begin
            port_b_next     = port_b_reg;
            port_a_next     = port_a_reg;
            port_a_mir_next = port_a_mir_reg;
            ddr_b_next      = ddr_b_reg;
            ddr_a_next      = ddr_a_reg;
            control_next    = control_reg;
            bank_set_next   = bank_set_reg;
        end

        // Version write reloads the control register
        if (cfg.valid && cfg.ready)
        begin
            version_next = cfg.data;
            control_next = CONTROL_BASE | {6'b000000, cfg.data};
        end
    end

    // Advance the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_b_reg     <= '0;
            port_a_reg     <= PORT_A_RESET;
            port_a_mir_reg <= '0;
            ddr_b_reg      <= DDR_B_RESET;
            ddr_a_reg      <= DDR_A_RESET;
            control_reg    <= CONTROL_BASE | {6'b000000, VERSION_RESET};
            bank_set_reg   <= '0;
            version_reg    <= VERSION_RESET;
        end
        else
        begin
            port_b_reg     <= port_b_next;
            port_a_reg     <= port_a_next;
            port_a_mir_reg <= port_a_mir_next;
            ddr_b_reg      <= ddr_b_next;
            ddr_a_reg      <= ddr_a_next;
            control_reg    <= control_next;
            bank_set_reg   <= bank_set_next;
            version_reg    <= version_next;
        end
    end

    // Plain VIA bytes, written at the decoded entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLAIN_COUNT; i++)
            begin
                plain_reg[i] <= '0;
            end
        end
        else if (in_xfer && is_write && plain_hit)
        begin
            plain_reg[plain_idx] <= bus_in.write_data;
        end
    end

    // Output buffer control: result register first, skid entry when it is occupied
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_xfer)
        begin
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            if (!out_valid_reg || out_xfer)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Move result payloads through the buffer
    always_ff @(posedge clk)
    begin
        if (out_xfer && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (in_xfer && (!out_valid_reg || out_xfer))
        begin
            out_data_reg <= res;
        end
        if (in_xfer && out_valid_reg && !out_xfer)
        begin
            skid_data_reg <= res;
        end
    end

    assign bus_in.ready           = !skid_valid_reg;
    assign bus_out.valid          = out_valid_reg;
    assign bus_out.read_data      = out_data_reg.read_data;
    assign bus_out.accepted       = out_data_reg.accepted;
    assign bus_out.mem_request    = out_data_reg.mem_request;
    assign bus_out.mem_write      = out_data_reg.mem_write;
    assign bus_out.mem_is_ram     = out_data_reg.mem_is_ram;
    assign bus_out.mem_bank       = out_data_reg.mem_bank;
    assign bus_out.mem_offset     = out_data_reg.mem_offset;
    assign bus_out.mem_write_data = out_data_reg.mem_write_data;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied while result register is empty");

    a_write_to_ram: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.mem_write) |->
            (out_data_reg.mem_is_ram && out_data_reg.mem_request))
        else $error("bank write issued to a store other than RAM");

    a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.mem_bank <= BANK_MAX))
        else $error("bank number out of range");

    a_version_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready) |=>
            (control_reg == (CONTROL_BASE | {6'b000000, $past(cfg.data)})))
        else $error("control register not reloaded after version write");

    a_mirror_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && is_write && bus_in.address == OFS_PORT_A) |=>
            (port_a_reg == port_a_mir_reg))
        else $error("port A mirror out of step after port A write");
`endif

endmodule

`default_nettype wire
